// ----- rtl/feod_pkg.sv -----
// Shared constants and types of the frame energy onset detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package feod_pkg;

  // Default values of the top level parameters
  localparam int unsigned MaxFrameDef   = 4096;
  localparam int unsigned SampleBitsDef = 16;

  // Fixed field widths
  localparam int unsigned FlW     = 13;  // frame_length register
  localparam int unsigned FloorW  = 16;  // energy_floor register
  localparam int unsigned RatioW  = 10;  // rise_ratio register, Q2.8
  localparam int unsigned RmsW    = 16;  // frame RMS, Q0.16
  localparam int unsigned IdxW    = 32;  // sample index and frame start
  localparam int unsigned LevelW  = 24;  // smoothed level, Q0.24

  // Shortest frame the block will ever use
  localparam int unsigned MinFrame = 256;

  // Smoothing weights in Q0.16, 0.92 and 0.08, summing to 65536
  localparam int unsigned KeepWeight = 60293;
  localparam int unsigned NewWeight  = 5243;
  localparam int unsigned KeepW      = 16;
  localparam int unsigned NewW       = 13;

  // Reset values of the configuration registers
  localparam logic [FlW-1:0]    FrameLengthRst = 13'd2400;
  localparam logic [FloorW-1:0] EnergyFloorRst = 16'd655;
  localparam logic [RatioW-1:0] RiseRatioRst   = 10'd302;

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegFrameLength = 2'd0;
  localparam logic [RegIdxW-1:0] RegEnergyFloor = 2'd1;
  localparam logic [RegIdxW-1:0] RegRiseRatio   = 2'd2;

  // Depth of the frame job queue between front and back
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } feod_q_status_t;

endpackage

// ----- rtl/feod_queue.sv -----
// Short job queue between the accumulating front and the arithmetic back.
// Depends on feod_pkg for the status struct.
`timescale 1ns / 1ps

module feod_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = feod_pkg::QDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output feod_pkg::feod_q_status_t status_o
);
  import feod_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/feod_front.sv -----
// Front end: takes samples, squares and accumulates them, cuts frames.
// Depends on feod_pkg; hands finished frames to feod_queue as jobs.
`timescale 1ns / 1ps

module feod_front #(
  parameter int unsigned MAX_FRAME   = feod_pkg::MaxFrameDef,
  parameter int unsigned SAMPLE_BITS = feod_pkg::SampleBitsDef,
  localparam int unsigned LenW = $clog2(MAX_FRAME + 1),
  localparam int unsigned SumW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME),
  localparam int unsigned JobW = 1 + feod_pkg::IdxW + LenW + SumW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          start_i,
  input  logic [feod_pkg::FlW-1:0]      frame_length_i,
  input  feod_pkg::feod_q_status_t      q_status_i,
  output logic                          push_o,
  output logic [JobW-1:0]               job_o
);
  import feod_pkg::*;

  localparam int unsigned SqW = 2 * SAMPLE_BITS;

  // Stage one: squared magnitude
  logic                   v1_q;
  logic [SqW-1:0]         sq_q;
  logic                   start_q;
  logic [SAMPLE_BITS-1:0] mag;

  // Stage two: frame accumulation
  logic [LenW-1:0] pos_q, base_pos, pos_new, len;
  logic [SumW-1:0] sum_q, base_sum, sum_new;
  logic [IdxW-1:0] idx_q, base_idx, idx_new;
  logic [IdxW-1:0] fs_q, base_fs;
  logic            clr_pend_q, clr_now;
  logic            ends, proceed;

  // Most negative sample folds onto 2^(SAMPLE_BITS-1), which is correct
  assign mag = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;

  // Clamp the frame length into the supported range
  always_comb begin
    if (frame_length_i < FlW'(MinFrame)) begin
      len = LenW'(MinFrame);
    end else if (32'(frame_length_i) > 32'(MAX_FRAME)) begin
      len = LenW'(MAX_FRAME);
    end else begin
      len = LenW'(frame_length_i);
    end
  end

  assign base_pos = start_q ? '0 : pos_q;
  assign base_sum = start_q ? '0 : sum_q;
  assign base_idx = start_q ? '0 : idx_q;
  assign base_fs  = start_q ? '0 : fs_q;
  assign clr_now  = clr_pend_q | start_q;

  assign pos_new = base_pos + 1'b1;
  assign sum_new = base_sum + SumW'(sq_q);
  assign idx_new = base_idx + 1'b1;
  assign ends    = (pos_new >= len);

  // Hold a frame-ending sample while the queue is full
  assign proceed = v1_q && (!ends || !q_status_i.full);
  assign ready_o = !v1_q || proceed;
  assign push_o  = proceed && ends;
  assign job_o   = {clr_now, base_fs, len, sum_new};

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sq_q    <= SqW'(mag) * SqW'(mag);
      start_q <= start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
      idx_q      <= '0;
      fs_q       <= '0;
      clr_pend_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v1_q <= valid_i;
      end
      if (proceed) begin
        idx_q <= idx_new;
        if (ends) begin
          pos_q      <= '0;
          sum_q      <= '0;
          fs_q       <= idx_new;
          clr_pend_q <= 1'b0;
        end else begin
          pos_q      <= pos_new;
          sum_q      <= sum_new;
          fs_q       <= base_fs;
          clr_pend_q <= clr_now;
        end
      end
    end
  end

endmodule

// ----- rtl/feod_back.sv -----
// Back end: per frame divide, square root, onset decision and level update.
// Depends on feod_pkg; takes jobs from feod_queue, drives the result register.
`timescale 1ns / 1ps

module feod_back #(
  parameter int unsigned MAX_FRAME   = feod_pkg::MaxFrameDef,
  parameter int unsigned SAMPLE_BITS = feod_pkg::SampleBitsDef,
  localparam int unsigned LenW = $clog2(MAX_FRAME + 1),
  localparam int unsigned SumW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME),
  localparam int unsigned JobW = 1 + feod_pkg::IdxW + LenW + SumW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [JobW-1:0]             job_i,
  input  feod_pkg::feod_q_status_t    q_status_i,
  output logic                        pop_o,
  input  logic [feod_pkg::FloorW-1:0] energy_floor_i,
  input  logic [feod_pkg::RatioW-1:0] rise_ratio_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        onset_o,
  output logic [feod_pkg::RmsW-1:0]   frame_rms_o,
  output logic [feod_pkg::IdxW-1:0]   frame_start_o
);
  import feod_pkg::*;

  // Scale the sum to Q0.32 of the mean square: left or right shift
  localparam int unsigned ShL     = (34 > 2 * SAMPLE_BITS) ? 34 - 2 * SAMPLE_BITS : 0;
  localparam int unsigned ShR     = (2 * SAMPLE_BITS > 34) ? 2 * SAMPLE_BITS - 34 : 0;
  localparam int unsigned ScaledW = SumW + ShL;
  localparam int unsigned QW      = ScaledW - 8;  // length is at least 256
  localparam int unsigned RootW   = (QW + 1) / 2;
  localparam int unsigned QPadW   = 2 * RootW;
  localparam int unsigned SremW   = RootW + 2;
  localparam int unsigned CntW    = $clog2(ScaledW + 1);
  localparam int unsigned ProdAW  = LevelW + RatioW;
  localparam int unsigned ProdBW  = LevelW + KeepW;
  localparam int unsigned ProdCW  = RmsW + 8 + NewW;
  localparam int unsigned AccW    = ProdBW + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StMulA = 3'd3;
  localparam logic [2:0] StMulB = 3'd4;
  localparam logic [2:0] StMulC = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q;
  logic [ScaledW-1:0] dq_q;
  logic [LenW:0]      rem_q;
  logic [LenW-1:0]    len_q;
  logic [IdxW-1:0]    start_q;
  logic [QPadW-1:0]   sq_q;
  logic [SremW-1:0]   srem_q;
  logic [RootW-1:0]   root_q;
  logic [RmsW-1:0]    rms_q;
  logic [ProdAW-1:0]  prod_a_q;
  logic [ProdBW-1:0]  prod_b_q;
  logic [ProdCW-1:0]  prod_c_q;
  logic [LevelW-1:0]  level_q;
  logic               out_valid_q, onset_q;
  logic [RmsW-1:0]    rms_out_q;
  logic [IdxW-1:0]    fs_out_q;

  logic               job_clr;
  logic [IdxW-1:0]    job_start;
  logic [LenW-1:0]    job_len;
  logic [SumW-1:0]    job_sum;
  logic [ScaledW-1:0] scaled;
  logic [LenW:0]      rem_sh, rem_sub;
  logic               div_ge;
  logic [SremW+1:0]   trial, test;
  logic               sqrt_ge;
  logic [RmsW-1:0]    root_sat;
  logic               slot_free, onset_d;
  logic [AccW-1:0]    level_acc;

  assign {job_clr, job_start, job_len, job_sum} = job_i;
  assign scaled = (ScaledW'(job_sum) << ShL) >> ShR;

  // One quotient bit per cycle, restoring
  assign rem_sh  = {rem_q[LenW-1:0], dq_q[ScaledW-1]};
  assign div_ge  = (rem_sh >= {1'b0, len_q});
  assign rem_sub = rem_sh - {1'b0, len_q};

  // One root bit per cycle, digit by digit
  assign trial   = {srem_q, sq_q[QPadW-1 -: 2]};
  assign test    = (SremW + 2)'({root_q, 2'b01});
  assign sqrt_ge = (trial >= test);

  assign root_sat  = (root_q > RootW'({RmsW{1'b1}})) ? {RmsW{1'b1}} : root_q[RmsW-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign onset_d   = ({2'b00, rms_q, 16'h0000} > prod_a_q) && (rms_q > energy_floor_i);
  assign level_acc = AccW'(prod_b_q) + AccW'(prod_c_q) + AccW'(32768);

  assign pop_o         = (state_q == StIdle) && !q_status_i.empty;
  assign out_valid_o   = out_valid_q;
  assign onset_o       = onset_q;
  assign frame_rms_o   = rms_out_q;
  assign frame_start_o = fs_out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (!q_status_i.empty) state_d = StDiv;
      StDiv:   if (cnt_q == CntW'(1)) state_d = StSqrt;
      StSqrt:  if (cnt_q == CntW'(1)) state_d = StMulA;
      StMulA:  state_d = StMulB;
      StMulB:  state_d = StMulC;
      StMulC:  state_d = StDone;
      StDone:  if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        dq_q    <= scaled;
        rem_q   <= '0;
        len_q   <= job_len;
        start_q <= job_start;
      end
      StDiv: begin
        dq_q  <= {dq_q[ScaledW-2:0], div_ge};
        rem_q <= div_ge ? rem_sub : rem_sh;
        if (cnt_q == CntW'(1)) begin
          sq_q   <= QPadW'({dq_q[QW-2:0], div_ge});
          srem_q <= '0;
          root_q <= '0;
        end
      end
      StSqrt: begin
        sq_q   <= {sq_q[QPadW-3:0], 2'b00};
        srem_q <= sqrt_ge ? SremW'(trial - test) : SremW'(trial);
        root_q <= {root_q[RootW-2:0], sqrt_ge};
      end
      StMulA: begin
        rms_q    <= root_sat;
        prod_a_q <= ProdAW'(level_q) * ProdAW'(rise_ratio_i);
      end
      StMulB: prod_b_q <= ProdBW'(level_q) * ProdBW'(KeepWeight);
      StMulC: prod_c_q <= ProdCW'({rms_q, 8'h00}) * ProdCW'(NewWeight);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      onset_q     <= 1'b0;
      rms_out_q   <= '0;
      fs_out_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          cnt_q <= CntW'(ScaledW);
          if (!q_status_i.empty && job_clr) begin
            level_q <= '0;
          end
        end
        StDiv:  cnt_q <= (cnt_q == CntW'(1)) ? CntW'(RootW) : cnt_q - 1'b1;
        StSqrt: cnt_q <= cnt_q - 1'b1;
        StDone: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            onset_q     <= onset_d;
            rms_out_q   <= rms_q;
            fs_out_q    <= start_q;
            level_q     <= level_acc[16 +: LevelW];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/frame_energy_onset_detector.sv -----
// Top level of the frame energy onset detector: configuration registers,
// stream ports and assertions. Depends on feod_pkg, feod_front, feod_queue, feod_back.
`timescale 1ns / 1ps

// Use: stream one signed audio sample per transaction on the s_axis channel,
// sample in tdata, stream start flag in tuser. A set start flag clears the
// frame, the smoothed level and the sample index before that sample counts.
// Every frame_length samples (clamped to 256 .. MAX_FRAME) one transaction
// leaves on m_axis: RMS and frame start index in tdata, onset flag in tuser.
// Throughput: one sample per cycle, sustained while the job queue has room. The front
// squares in one stage and accumulates in the next; the per-frame arithmetic runs in
// the back: one quotient bit per cycle, one root bit per cycle, three multiply steps
// and a write step. A two-entry job queue lets the front keep taking samples while
// the back works or while m_axis is stalled; only a frame end meeting a full queue
// drops s_axis_tready. Reset clears all counters, the level and the queue and loads
// the configuration defaults. Write configuration over APB only while the block
// is idle.

module frame_energy_onset_detector #(
  parameter int unsigned MAX_FRAME   = feod_pkg::MaxFrameDef,
  parameter int unsigned SAMPLE_BITS = feod_pkg::SampleBitsDef,
  localparam int unsigned InDataW    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [feod_pkg::AddrW-1:0]   paddr,
  input  logic [feod_pkg::DataW-1:0]   pwdata,
  output logic [feod_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  // Sample input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [InDataW-1:0]           s_axis_tdata,  // sample
  input  logic                         s_axis_tuser,  // stream_start
  // Frame results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [47:0]                  m_axis_tdata,  // frame_rms, frame_start
  output logic                         m_axis_tuser   // onset
);
  import feod_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_FRAME + 1);
  localparam int unsigned SumW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME);
  localparam int unsigned JobW = 1 + IdxW + LenW + SumW;

  logic [FlW-1:0]    frame_length_q;
  logic [FloorW-1:0] energy_floor_q;
  logic [RatioW-1:0] rise_ratio_q;
  logic              cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  logic           push, pop;
  logic [JobW-1:0] job_in, job_out;
  feod_q_status_t q_status;

  logic [RmsW-1:0] frame_rms;
  logic [IdxW-1:0] frame_start;

  // Configuration port: zero wait states, registers at 4*i
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FrameLengthRst;
      energy_floor_q <= EnergyFloorRst;
      rise_ratio_q   <= RiseRatioRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegFrameLength: frame_length_q <= pwdata[FlW-1:0];
        RegEnergyFloor: energy_floor_q <= pwdata[FloorW-1:0];
        RegRiseRatio:   rise_ratio_q   <= pwdata[RatioW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFrameLength: prdata = DataW'(frame_length_q);
      RegEnergyFloor: prdata = DataW'(energy_floor_q);
      RegRiseRatio:   prdata = DataW'(rise_ratio_q);
      default:        prdata = '0;
    endcase
  end

  // Accumulate samples and cut frames
  feod_front #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .sample_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .start_i        (s_axis_tuser),
    .frame_length_i (frame_length_q),
    .q_status_i     (q_status),
    .push_o         (push),
    .job_o          (job_in)
  );

  // Decouple frame cutting from the per-frame arithmetic
  feod_queue #(
    .WIDTH (JobW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .pop_i    (pop),
    .data_o   (job_out),
    .status_o (q_status)
  );

  // Root, onset decision and level tracking
  feod_back #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_out),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .energy_floor_i (energy_floor_q),
    .rise_ratio_i   (rise_ratio_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .onset_o        (m_axis_tuser),
    .frame_rms_o    (frame_rms),
    .frame_start_o  (frame_start)
  );

  assign m_axis_tdata = {frame_start, frame_rms};

`ifndef NO_ASSERTIONS
  // Never push a job into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("frame job pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("frame job popped from empty queue");

  // An onset must clear the absolute floor
  a_onset_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[15:0] > energy_floor_q))
    else $error("onset flagged at or below the energy floor");

  // Input stalls only while a frame end waits on a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_status.full)
    else $error("input stalled with room in the queue");
`endif

endmodule

// ----- sim/tb_frame_energy_onset_detector.sv -----
// Self-checking testbench of frame_energy_onset_detector: streams audio samples,
// predicts the RMS, onset flag and start index of each frame and checks them.
// Depends on feod_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_frame_energy_onset_detector;
  import feod_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  // Time left for the back end to go quiet after the last result, with ample margin
  localparam int unsigned DrainWait   = 150;
  localparam int unsigned CycleLimit  = 600000;
  // Long enough for the job queue and the back end to fill at 256-sample frames
  localparam int unsigned HoldOffLen  = 3000;
  localparam int          SampleMax   = 32767;
  localparam int          SampleMin   = -32768;
  // Energy scaling to Q0.32 before the root: 2^(34 - 2*sample bits)
  localparam int unsigned EnergyShift = 34 - 2 * SampleBitsDef;
  // Address that decodes to no register
  localparam logic [RegIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic            onset;
    logic [RmsW-1:0] rms;
    logic [IdxW-1:0] start;
  } frame_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // sample
  logic              s_axis_tuser;   // stream_start
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // frame_rms [15:0], frame_start [47:16]
  logic              m_axis_tuser;   // onset

  // Predicted copy of the configuration and of the block's frame state
  logic [FlW-1:0]    len_reg;
  logic [FloorW-1:0] floor_reg;
  logic [RatioW-1:0] ratio_reg;
  int unsigned       samples_in_frame;
  logic [63:0]       frame_energy;
  logic [LevelW-1:0] level;
  logic [IdxW-1:0]   next_index;
  logic [IdxW-1:0]   frame_first;
  frame_result_t     expected_frames[$];
  int unsigned       frames_predicted;

  // Checker and stall bookkeeping
  frame_result_t     got;
  frame_result_t     want;
  int unsigned       frames_checked;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  int unsigned       hold_requests;
  int unsigned       holds_served;
  int unsigned       hold_left;

  frame_energy_onset_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #ClkHalf;
    clk_i = 1'b1;
    #ClkHalf;
  end

  // Floor of the square root, one result bit at a time from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [15:0] pick_sample(input int lo, input int hi);
    int v;
    v = lo + int'($urandom_range(hi - lo));
    return v[15:0];
  endfunction

  task automatic reset_prediction();
    len_reg          = FrameLengthRst;
    floor_reg        = EnergyFloorRst;
    ratio_reg        = RiseRatioRst;
    samples_in_frame = 0;
    frame_energy     = '0;
    level            = '0;
    next_index       = '0;
    frame_first      = '0;
    frames_predicted = 0;
  endtask

  // Fold one accepted sample into the predicted frame; queue the frame result
  // when the sample closes the frame.
  task automatic account_sample(input logic signed [15:0] smp, input logic restart);
    int            mag;
    int unsigned   span;
    logic [63:0]   root;
    logic [63:0]   threshold;
    logic [63:0]   level_next;
    frame_result_t res;
    if (restart) begin
      samples_in_frame = 0;
      frame_energy     = '0;
      level            = '0;
      next_index       = '0;
      frame_first      = '0;
    end
    mag = smp;
    if (mag < 0) mag = -mag;
    frame_energy += 64'(mag) * 64'(mag);
    samples_in_frame++;
    next_index++;
    // Clamp the frame length to the range the block supports
    span = len_reg;
    if (span < MinFrame) span = MinFrame;
    if (span > MaxFrameDef) span = MaxFrameDef;
    if (samples_in_frame >= span) begin
      root = floor_sqrt((frame_energy << EnergyShift) / span);
      if (root > 64'd65535) root = 64'd65535;
      // Compare against the level from before this frame's update
      threshold = 64'(level) * 64'(ratio_reg);
      res.onset = ((root << 16) > threshold) && (root > 64'(floor_reg));
      res.rms   = root[RmsW-1:0];
      res.start = frame_first;
      expected_frames.push_back(res);
      frames_predicted++;
      level_next = (64'(level) * KeepWeight + (root << 8) * NewWeight + 64'd32768) >> 16;
      level            = level_next[LevelW-1:0];
      samples_in_frame = 0;
      frame_energy     = '0;
      frame_first      = next_index;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] predicted);
    $display("%0t ns frame %0d: %s is %0h, expected %0h", $time, frames_checked, what,
             seen, predicted);
    mismatches++;
  endtask

  // Offer one sample, idling at random beforehand; return once the transaction
  // has been taken.
  task automatic send_sample(input logic [15:0] smp, input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    account_sample(smp, restart);
  endtask

  task automatic send_run(input int n, input int lo, input int hi, input bit restart_first);
    for (int k = 0; k < n; k++) send_sample(pick_sample(lo, hi), restart_first && (k == 0));
  endtask

  // Stop offering, wait for every predicted frame, then let the back end go quiet
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write over APB with random bits above the field, which the block drops
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    int unsigned      w;
    logic [DataW-1:0] data;
    case (idx)
      RegFrameLength: w = FlW;
      RegEnergyFloor: w = FloorW;
      RegRiseRatio:   w = RatioW;
      default:        w = 0;
    endcase
    data = (DataW'($urandom()) << w) | value;
    settle_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegFrameLength: len_reg   = data[FlW-1:0];
      RegEnergyFloor: floor_reg = data[FloorW-1:0];
      RegRiseRatio:   ratio_reg = data[RatioW-1:0];
      default: ;
    endcase
  endtask

  // Two frames under the reset configuration: 2400 samples each, default floor and ratio
  task automatic test_reset_defaults();
    send_run(2400, -3000, 3000, 1'b0);
    send_run(2400, -200, 200, 1'b0);
  endtask

  // Full-scale and silent frames at the shortest length; the all most-negative
  // frame reaches an RMS of one and must saturate.
  task automatic test_full_scale();
    write_reg(RegFrameLength, 32'd256);
    send_run(256, SampleMin, SampleMin, 1'b0);
    send_run(256, SampleMax, SampleMax, 1'b0);
    send_run(256, 0, 0, 1'b0);
    send_run(256, -1, 1, 1'b0);
    send_run(256, SampleMin, SampleMax, 1'b0);
  endtask

  // Floor and ratio at their extremes, a ratio below one among them
  task automatic test_floor_and_ratio();
    write_reg(RegEnergyFloor, 32'd65535);
    send_run(256, SampleMin, SampleMin, 1'b0);
    write_reg(RegEnergyFloor, 32'd0);
    write_reg(RegRiseRatio, 32'd0);
    send_run(256, -1, 1, 1'b0);
    send_run(256, 0, 0, 1'b0);
    write_reg(RegRiseRatio, 32'd255);
    send_run(256, -500, 500, 1'b0);
    send_run(256, -400, 400, 1'b0);
    write_reg(RegRiseRatio, 32'd1023);
    send_run(256, -900, 900, 1'b0);
    send_run(256, -30000, 30000, 1'b0);
  endtask

  // Lengths below and above the supported range clamp to 256 and MAX_FRAME
  task automatic test_length_limits();
    write_reg(RegEnergyFloor, 32'd655);
    write_reg(RegRiseRatio, 32'd302);
    write_reg(RegFrameLength, 32'd0);
    send_run(256, -8000, 8000, 1'b0);
    write_reg(RegFrameLength, 32'd255);
    send_run(256, -16000, 16000, 1'b0);
    write_reg(RegFrameLength, 32'd257);
    send_run(257, -100, 100, 1'b0);
    write_reg(RegFrameLength, 32'd4096);
    send_run(4096, SampleMin, SampleMax, 1'b0);
    write_reg(RegFrameLength, 32'd8191);
    send_run(4096, -20, 20, 1'b0);
  endtask

  // Shorten the frame below its current fill: the next sample must close it.
  // Then lengthen a partly filled frame.
  task automatic test_length_change_mid_frame();
    write_reg(RegFrameLength, 32'd1024);
    send_run(600, -5000, 5000, 1'b0);
    write_reg(RegFrameLength, 32'd300);
    send_run(1, 1234, 1234, 1'b0);
    send_run(200, -700, 700, 1'b0);
    write_reg(RegFrameLength, 32'd700);
    send_run(500, -12000, 12000, 1'b0);
  endtask

  // Stream start mid frame, just before a frame end and on back-to-back samples
  task automatic test_stream_start();
    write_reg(RegFrameLength, 32'd256);
    send_run(100, -4000, 4000, 1'b0);
    send_run(256, -4000, 4000, 1'b1);
    send_run(255, -9000, 9000, 1'b0);
    send_run(1, SampleMax, SampleMax, 1'b1);
    send_run(1, SampleMin, SampleMin, 1'b1);
    send_run(300, -6000, 6000, 1'b0);
  endtask

  // A write to the unused address must leave every register as it was
  task automatic test_spare_register();
    write_reg(RegSpare, 32'd0);
    send_run(512, -2500, 2500, 1'b0);
  endtask

  // Hold the result side off while samples keep coming, so that the job queue
  // fills and the input stalls; then pause until every result is out.
  task automatic test_output_stall();
    write_reg(RegFrameLength, 32'd256);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    send_run(2048, -20000, 20000, 1'b0);
    settle_idle();
  endtask

  // Random streams in bursts of one loudness each, so that the smoothed level
  // settles and loud bursts stand out as onsets; two settings per call.
  task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned goal;
    int          amp;
    int          burst;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int setting = 0; setting < 2; setting++) begin
      write_reg(RegFrameLength, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(256, 400));
      write_reg(RegEnergyFloor, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(2000));
      write_reg(RegRiseRatio, $urandom_range(1023));
      goal = frames_predicted + 7;
      while (frames_predicted < goal) begin
        burst = $urandom_range(32, 300);
        case ($urandom_range(9))
          0, 1:    amp = $urandom_range(16);
          2, 3, 4: amp = $urandom_range(200, 2500);
          5, 6, 7: amp = $urandom_range(6000, SampleMax);
          default: amp = -SampleMin;
        endcase
        for (int k = 0; k < burst; k++)
          send_sample(pick_sample(-amp, (amp > SampleMax) ? SampleMax : amp),
                      $urandom_range(799) == 0);
      end
    end
  endtask

  // Result side: check each transaction against the oldest prediction, then
  // decide readiness for the next cycle, honouring any requested hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.onset = m_axis_tuser;
      got.rms   = m_axis_tdata[15:0];
      got.start = m_axis_tdata[47:16];
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected frame result", got, '0);
      end else begin
        want = expected_frames.pop_front();
        if (got.onset !== want.onset) report_mismatch("onset", got.onset, want.onset);
        if (got.rms !== want.rms) report_mismatch("frame_rms", got.rms, want.rms);
        if (got.start !== want.start) report_mismatch("frame_start", got.start, want.start);
      end
      frames_checked++;
    end
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HoldOffLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: a run that far exceeds the slowest correct one has hung
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_frame_energy_onset_detector: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= 1'b0;
    m_axis_tready  <= 1'b0;
    hold_requests  <= 0;
    holds_served   = 0;
    hold_left      = 0;
    frames_checked = 0;
    mismatches     = 0;
    cycle_count    = 0;
    src_idle_pct   = 32;
    snk_idle_pct   = 57;
    reset_prediction();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender idling lightly and receiver heavily
    test_reset_defaults();
    test_full_scale();
    test_floor_and_ratio();
    test_length_limits();
    test_length_change_mid_frame();
    test_stream_start();
    test_spare_register();

    // Random part: swap the idling sides, then run flat out after the stall test
    run_random_phase(32, 57);
    run_random_phase(57, 32);
    test_output_stall();
    run_random_phase(0, 0);

    settle_idle();
    if (mismatches == 0) begin
      $display("tb_frame_energy_onset_detector: done, clean");
    end else begin
      $display("tb_frame_energy_onset_detector: done, errors");
    end
    $finish;
  end

endmodule
